/* design/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;
	typedef logic [31:0] word_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic       start;
		logic [3:0] wrd_idx;
		word_t      wrd;
		logic       wrd_wr;
	} round_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} round_sts_t;
endpackage

/* design/sha_if.sv */
`timescale 1ns / 1ps
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;
	modport source (output valid, digest_word, word_index, final_word, input ready);
	modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

/* design/sha_round.sv */
`timescale 1ns / 1ps
// One SHA-256 round per cycle over a rolling 16-word schedule window.
// The chaining words are updated in place when the 64th round completes.
module sha_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha_pkg::round_ctl_t   ctl,
	input  logic                  reinit,
	output sha_pkg::round_sts_t   sts,
	output sha_pkg::word_t        hash [8]
);
	sha_pkg::word_t w_q [16];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t h_q [8];
	logic [5:0]     rnd_q;
	logic           busy_q;
	logic           done_q;

	function automatic sha_pkg::word_t ror(sha_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	sha_pkg::word_t s0, s1, w_new, big0, big1, chs, maj, t1, t2;

	always_comb begin
		s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		big1  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		chs   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + chs + sha_pkg::ROUND_K[rnd_q] + w_q[0];
		big0  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
		end else begin
			done_q <= 1'b0;
			if (reinit) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
			end
			if (ctl.wrd_wr) w_q[ctl.wrd_idx] <= ctl.wrd;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end else if (busy_q) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				rnd_q  <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					h_q[0] <= h_q[0] + t1 + t2;
					h_q[1] <= h_q[1] + v_q[0];
					h_q[2] <= h_q[2] + v_q[1];
					h_q[3] <= h_q[3] + v_q[2];
					h_q[4] <= h_q[4] + v_q[3] + t1;
					h_q[5] <= h_q[5] + v_q[4];
					h_q[6] <= h_q[6] + v_q[5];
					h_q[7] <= h_q[7] + v_q[6];
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	always_comb for (int i = 0; i < 8; i++) hash[i] = h_q[i];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("done without rounds");
	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> rnd_q == 6'd0 || $past(rnd_q) == 6'd63) else $error("round count");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q) else $error("start while busy");
endmodule

/* design/sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   data_byte[7:0], byte_present, end_of_message
// out_ch    out  digest_word[31:0], word_index[2:0], final_word
//
// A byte that does not fill a block is simply accepted; the 64th byte starts
// 64 rounds of the shared round unit, and no further byte is taken until the
// compression completes. An end mark loads a padded block word by word and compresses it,
// twice when the length does not fit, then offers eight digest words, one per
// cycle when taken. Reset restores the initial hash values and clears the count.
// A stalled output holds the current word; no input is taken meanwhile.
module sha256_byte_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	typedef enum logic [2:0] {ST_IDLE, ST_COMP, ST_PAD, ST_EMIT} state_t;

	state_t            state_q;
	logic [60:0]       cnt_q;
	logic [23:0]       part_q;     // bytes of the word being collected
	logic [3:0]        widx_q;
	logic              last_q;     // message has ended; padding follows
	logic              pad_more_q; // second padded block of two
	logic              msg_blk_q;  // compression running holds message bytes
	logic [2:0]        oidx_q;
	sha_pkg::round_ctl_t ctl;
	sha_pkg::round_sts_t sts;
	sha_pkg::word_t    hash [8];
	logic              reinit;

	logic [5:0]  pos;
	logic [63:0] bits;
	logic        acc;

	assign acc  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign pos  = cnt_q[5:0];
	assign bits = {cnt_q, 3'b000};

	// Padded byte at position p, built from the stored byte and the bit count.
	function automatic logic [7:0] pad_byte(logic [5:0] p, logic [5:0] lim,
			logic two, logic second, logic [63:0] b, logic [7:0] stored);
		logic [7:0] r;
		r = 8'h00;
		if (!second && p < lim) r = stored;
		else if (!second && p == lim) r = sha_pkg::PAD_BYTE;
		if (p >= 6'd56 && !(two && !second)) r = b[8*(7-p[2:0]) +: 8];
		return r;
	endfunction

	// Bytes already collected for the current word, left aligned.
	logic [31:0] part_word;
	always_comb begin
		case (pos[1:0])
			2'd1:    part_word = {part_q[7:0], 24'h000000};
			2'd2:    part_word = {part_q[15:0], 16'h0000};
			2'd3:    part_word = {part_q, 8'h00};
			default: part_word = '0;
		endcase
	end

	logic [31:0] pad_word;
	always_comb begin
		logic [5:0] bp;
		for (int k = 0; k < 4; k++) begin
			bp = {widx_q, 2'(k)};
			pad_word[31-8*k -: 8] = pad_byte(bp, pos, pos >= 6'd56,
				pad_more_q, bits, part_word[31-8*k -: 8]);
		end
	end

	// Complete message words below the end position stay in the schedule window.
	always_comb begin
		ctl = '0;
		if (state_q == ST_IDLE && acc && in_ch.byte_present && pos[1:0] == 2'd3) begin
			ctl.wrd_wr  = 1'b1;
			ctl.wrd_idx = pos[5:2];
			ctl.wrd     = {part_q, in_ch.data_byte};
		end
		if (state_q == ST_PAD) begin
			ctl.wrd_wr  = pad_more_q || (widx_q >= pos[5:2]);
			ctl.wrd_idx = widx_q;
			ctl.wrd     = pad_word;
			ctl.start   = (widx_q == 4'd15);
		end
		if (state_q == ST_IDLE && acc && in_ch.byte_present && pos == 6'd63)
			ctl.start = 1'b1;
	end

	assign reinit = (state_q == ST_EMIT) && out_ch.ready && oidx_q == 3'd7;

	sha_round u_round (.clk, .arst_n, .ctl, .reinit, .sts, .hash);

	// pad_more_q marks the second of two padded blocks; last_q that the message has ended.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			part_q     <= '0;
			widx_q     <= '0;
			last_q     <= 1'b0;
			pad_more_q <= 1'b0;
			msg_blk_q  <= 1'b0;
			oidx_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					widx_q <= '0;
					if (in_ch.byte_present) begin
						cnt_q  <= cnt_q + 61'd1;
						part_q <= {part_q[15:0], in_ch.data_byte};
					end
					last_q     <= in_ch.end_of_message;
					pad_more_q <= 1'b0;
					msg_blk_q  <= in_ch.byte_present && pos == 6'd63;
					if (in_ch.byte_present && pos == 6'd63) state_q <= ST_COMP;
					else if (in_ch.end_of_message) begin
						state_q    <= ST_PAD;
						pad_more_q <= 1'b0;
					end
				end
				ST_PAD: begin
					widx_q <= widx_q + 4'd1;
					if (widx_q == 4'd15) state_q <= ST_COMP;
				end
				ST_COMP: if (sts.done) begin
					if (!last_q) state_q <= ST_IDLE;
					else if (msg_blk_q) begin
						// The end came with the 64th byte: a full padded block follows.
						msg_blk_q <= 1'b0;
						widx_q    <= '0;
						state_q   <= ST_PAD;
					end else if (!pad_more_q && pos >= 6'd56) begin
						pad_more_q <= 1'b1;
						widx_q     <= '0;
						state_q    <= ST_PAD;
					end else begin
						oidx_q  <= '0;
						state_q <= ST_EMIT;
					end
				end else if (!sts.busy && !ctl.start) begin
					state_q <= ST_PAD;
				end
				ST_EMIT: if (out_ch.ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.digest_word = hash[oidx_q];
	assign out_ch.word_index  = oidx_q;
	assign out_ch.final_word  = (oidx_q == 3'd7);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while emitting");
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.final_word |=> out_ch.valid)
		else $error("digest burst broken");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.final_word |=> cnt_q == 61'd0)
		else $error("count not cleared");
endmodule
